@@ rtl/mdc_pkg.sv @@
// Package for the message ID deduplication cache: widths, reset values,
// request/result structs, register indexes, state and command types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mdc_pkg;

	localparam int MDC_ENTRIES = 4;

	localparam int ID_W     = 16;
	localparam int TIME_W   = 40;
	localparam int ACK_W    = 16;
	localparam int RETX_W   = 4;
	localparam int FACTOR_W = 10;
	localparam int LAT_W    = 20;
	localparam int CFG_W    = 20;

	// the ack time-out times (2^retransmit - 1) fits in ACK_W + 2^RETX_W - 1 bits
	localparam int SPAN_W = ACK_W + (1 << RETX_W) - 1;
	localparam int PROD_W = SPAN_W + FACTOR_W;
	localparam int LIFE_W = PROD_W - 8 + 1;

	localparam logic [ACK_W-1:0]    ACK_RESET    = ACK_W'(2000);
	localparam logic [RETX_W-1:0]   RETX_RESET   = RETX_W'(4);
	localparam logic [FACTOR_W-1:0] FACTOR_RESET = FACTOR_W'(384);
	localparam logic [LAT_W-1:0]    LAT_RESET    = LAT_W'(100000);

	typedef enum logic [1:0] {
		REG_ACK_TMO       = 2'd0,
		REG_MAX_RETX      = 2'd1,
		REG_RANDOM_FACTOR = 2'd2,
		REG_MAX_LATENCY   = 2'd3
	} reg_index_t;

	typedef enum logic [1:0] {
		STATUS_STORED     = 2'd0,
		STATUS_MISS       = 2'd1,
		STATUS_HIT_RECENT = 2'd2,
		STATUS_HIT_OLDER  = 2'd3
	} status_t;

	typedef enum logic {
		OP_CHECK = 1'b0,
		OP_ADD   = 1'b1
	} opcode_t;

	typedef struct packed {
		logic               opcode;
		logic [ID_W-1:0]    msg_id;
		logic [TIME_W-1:0]  time_now_ms;
	} mdc_req_t;

	typedef struct packed {
		status_t status;
		logic    retransmission;
	} mdc_res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXPIRE,
		ST_LIFE1,
		ST_LIFE2,
		ST_SCAN,
		ST_COMMIT,
		ST_LOOKUP,
		ST_RESPOND
	} mdc_state_t;

	typedef struct packed {
		logic load;
		logic expire;
		logic scan_clr;
		logic scan_step;
		logic commit;
		logic lookup;
	} mdc_cmd_t;

	typedef struct packed {
		logic is_add;
		logic recent_valid;
		logic scan_done;
	} mdc_sts_t;

endpackage

`default_nettype wire

@@ rtl/message_id_dedup_cache_unit.sv @@
// Top level of the message ID deduplication cache.
// Instantiates mdc_ctrl and mdc_dpath; depends on mdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

// A request is taken when start is high and busy is low; busy then stays
// high until the result has gone out. Every request gives exactly one
// result, shown on result for the single cycle in which done is high; the
// receiver cannot stall, so capture it in that cycle. A check passes
// through expire and lookup before done. An add passes through expire
// and a lifetime wait, skips the victim search when the recent entry is
// empty or has expired, and then commits: the victim search walks the
// older slots one per cycle and stops early on the first free slot, and
// the commit waits for the registered lifetime chain of four stages
// (shift-subtract, one 31x10 multiply, add, then add to the time and
// saturate). The cache is ready straight after reset. Write the registers
// with wr_en, wr_index and wr_data only while busy is low; a write in the
// cycle before start is honoured by that request.
module message_id_dedup_cache_unit #(
	parameter int ENTRIES = mdc_pkg::MDC_ENTRIES
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      start,
	output logic                     busy,
	input  mdc_pkg::mdc_req_t        request,
	output logic                     done,
	output mdc_pkg::mdc_res_t        result,
	input  wire                      wr_en,
	input  wire [1:0]                wr_index,
	input  wire [mdc_pkg::CFG_W-1:0] wr_data
);
	import mdc_pkg::*;

	mdc_cmd_t cmd;
	mdc_sts_t sts;

	// sequencer: advance through expire, then lifetime wait, scan and commit for an add, or lookup for a check
	mdc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// storage, arithmetic and lookup; hold the result until the next request
	mdc_dpath #(
		.ENTRIES (ENTRIES)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (request),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cmd      (cmd),
		.sts      (sts),
		.result   (result)
	);

endmodule

`default_nettype wire

@@ rtl/mdc_ctrl.sv @@
// Sequencing state machine of the deduplication cache.
// Depends on mdc_pkg for the state, command and status types.
`timescale 1ns / 1ps
`default_nettype none

module mdc_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	input  mdc_pkg::mdc_sts_t sts,
	output mdc_pkg::mdc_cmd_t cmd,
	output logic             busy,
	output logic             done
);
	import mdc_pkg::*;

	mdc_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		done    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_EXPIRE;
				end
			end
			ST_EXPIRE: begin
				cmd.expire = 1'b1;
				state_d    = sts.is_add ? ST_LIFE1 : ST_LOOKUP;
			end
			// wait for the lifetime chain to settle
			ST_LIFE1: begin
				cmd.scan_clr = 1'b1;
				state_d      = ST_LIFE2;
			end
			ST_LIFE2: begin
				state_d = sts.recent_valid ? ST_SCAN : ST_COMMIT;
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_done) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = ST_RESPOND;
			end
			ST_LOOKUP: begin
				cmd.lookup = 1'b1;
				state_d    = ST_RESPOND;
			end
			ST_RESPOND: begin
				done    = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/mdc_dpath.sv @@
// Datapath of the deduplication cache: configuration registers, lifetime
// chain, entry store, victim scan and lookup. Depends on mdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mdc_dpath #(
	parameter int ENTRIES = mdc_pkg::MDC_ENTRIES
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  mdc_pkg::mdc_req_t       request,
	input  wire                     wr_en,
	input  wire [1:0]               wr_index,
	input  wire [mdc_pkg::CFG_W-1:0] wr_data,
	input  mdc_pkg::mdc_cmd_t       cmd,
	output mdc_pkg::mdc_sts_t       sts,
	output mdc_pkg::mdc_res_t       result
);
	import mdc_pkg::*;

	localparam int OLDER = ENTRIES - 1;
	localparam int IW    = (OLDER > 1) ? $clog2(OLDER) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(OLDER - 1);

	// configuration
	logic [ACK_W-1:0]    ack_q;
	logic [RETX_W-1:0]   retx_q;
	logic [FACTOR_W-1:0] factor_q;
	logic [LAT_W-1:0]    lat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_q    <= ACK_RESET;
			retx_q   <= RETX_RESET;
			factor_q <= FACTOR_RESET;
			lat_q    <= LAT_RESET;
		end else if (wr_en) begin
			case (reg_index_t'(wr_index))
				REG_ACK_TMO:       ack_q    <= wr_data[ACK_W-1:0];
				REG_MAX_RETX:      retx_q   <= wr_data[RETX_W-1:0];
				REG_RANDOM_FACTOR: factor_q <= wr_data[FACTOR_W-1:0];
				REG_MAX_LATENCY:   lat_q    <= wr_data[LAT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// latched request
	logic              op_q;
	logic [ID_W-1:0]   id_q;
	logic [TIME_W-1:0] now_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= request.opcode;
			id_q  <= request.msg_id;
			now_q <= request.time_now_ms;
		end
	end

	// lifetime chain: span, product, lifetime, saturated expiry
	logic [SPAN_W-1:0]   span_q;
	logic [PROD_W-1:0]   prod_q;
	logic [LIFE_W-1:0]   life_q;
	logic [TIME_W-1:0]   exp_q;
	logic [TIME_W:0]     exp_sum;

	assign exp_sum = {1'b0, now_q} + (TIME_W+1)'(life_q);

	always_ff @(posedge clk) begin
		span_q <= (SPAN_W'(ack_q) << retx_q) - SPAN_W'(ack_q);
		prod_q <= PROD_W'(span_q) * PROD_W'(factor_q);
		life_q <= LIFE_W'(prod_q[PROD_W-1:8]) + LIFE_W'({lat_q, 1'b0}) + LIFE_W'(ack_q);
		exp_q  <= exp_sum[TIME_W] ? {TIME_W{1'b1}} : exp_sum[TIME_W-1:0];
	end

	// entry store
	logic [ID_W-1:0]   recent_id_q;
	logic [TIME_W-1:0] recent_exp_q;
	logic              recent_valid_q;
	logic [ID_W-1:0]   older_id_q  [OLDER];
	logic [TIME_W-1:0] older_exp_q [OLDER];
	logic [OLDER-1:0]  older_valid_q;

	// victim scan
	logic [IW-1:0]     idx_q;
	logic [IW-1:0]     cand_q;
	logic [TIME_W-1:0] best_q;
	logic              have_q;
	logic              scan_done;

	assign scan_done = !older_valid_q[idx_q] || (idx_q == LAST_IDX);

	always_ff @(posedge clk) begin
		if (cmd.scan_clr) begin
			idx_q  <= '0;
			have_q <= 1'b0;
		end else if (cmd.scan_step) begin
			if (!older_valid_q[idx_q]) begin
				cand_q <= idx_q;
			end else if (!have_q || older_exp_q[idx_q] <= best_q) begin
				have_q <= 1'b1;
				best_q <= older_exp_q[idx_q];
				cand_q <= idx_q;
			end
			if (!scan_done) begin
				idx_q <= idx_q + IW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_valid_q <= 1'b0;
			older_valid_q  <= '0;
		end else if (cmd.expire) begin
			if (recent_valid_q && recent_exp_q < now_q) begin
				recent_valid_q <= 1'b0;
			end
			for (int i = 0; i < OLDER; i++) begin
				if (older_valid_q[i] && older_exp_q[i] < now_q) begin
					older_valid_q[i] <= 1'b0;
				end
			end
		end else if (cmd.commit) begin
			if (recent_valid_q) begin
				older_valid_q[cand_q] <= 1'b1;
			end
			recent_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (recent_valid_q) begin
				older_id_q[cand_q]  <= recent_id_q;
				older_exp_q[cand_q] <= recent_exp_q;
			end
			recent_id_q  <= id_q;
			recent_exp_q <= exp_q;
		end
	end

	// lookup and result
	logic    older_hit;
	logic    recent_hit;
	status_t status_q;
	logic    retrans_q;

	assign recent_hit = recent_valid_q && (recent_id_q == id_q);

	always_comb begin
		older_hit = 1'b0;
		for (int i = 0; i < OLDER; i++) begin
			if (older_valid_q[i] && older_id_q[i] == id_q) begin
				older_hit = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retrans_q <= 1'b0;
		end else if (cmd.lookup && recent_hit) begin
			retrans_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q <= STATUS_STORED;
		end else if (cmd.lookup) begin
			if (recent_hit) begin
				status_q <= STATUS_HIT_RECENT;
			end else if (older_hit) begin
				status_q <= STATUS_HIT_OLDER;
			end else begin
				status_q <= STATUS_MISS;
			end
		end
	end

	assign sts.is_add        = (opcode_t'(op_q) == OP_ADD);
	assign sts.recent_valid  = recent_valid_q;
	assign sts.scan_done     = scan_done;

	assign result.status         = status_q;
	assign result.retransmission = retrans_q;

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// Testbench for message_id_dedup_cache_unit: a directed table, then random request
// streams under several register settings, checked against a cycle-free cache model,
// typed rows against their own results. Depends on mdc_pkg and the cache unit RTL.
`timescale 1ns / 1ps

module tb;
	import mdc_pkg::*;

	localparam int OLDER = MDC_ENTRIES - 1;
	localparam logic [TIME_W-1:0] TIME_MAX = '1;
	localparam int DIR_N = 24;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 115;

	// One row of the directed table; typed rows carry their own expected result
	typedef struct packed {
		opcode_t           op;
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] t_ms;
		logic              typed;
		status_t           st;
		logic              rt;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	mdc_req_t request = '0;
	logic done;
	mdc_res_t result;
	logic wr_en = 1'b0;
	logic [1:0] wr_index = '0;
	logic [CFG_W-1:0] wr_data = '0;

	// Model copy of the registers
	logic [ACK_W-1:0]    cfg_ack;
	logic [RETX_W-1:0]   cfg_retx;
	logic [FACTOR_W-1:0] cfg_factor;
	logic [LAT_W-1:0]    cfg_lat;

	// Model copy of the cache
	logic [ID_W-1:0]   m_recent_id;
	logic [TIME_W-1:0] m_recent_exp;
	logic              m_recent_vld;
	logic [ID_W-1:0]   m_old_id  [0:OLDER-1];
	logic [TIME_W-1:0] m_old_exp [0:OLDER-1];
	logic              m_old_vld [0:OLDER-1];
	logic              m_retx;

	mdc_res_t pending_outcomes[$];
	int errors = 0;
	int calm_left = 0;
	bit quiet = 0;

	dir_row_t dir_rows [0:DIR_N-1];

	message_id_dedup_cache_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.request  (request),
		.done     (done),
		.result   (result),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic cache_reset();
		cfg_ack = ACK_RESET;
		cfg_retx = RETX_RESET;
		cfg_factor = FACTOR_RESET;
		cfg_lat = LAT_RESET;
		m_recent_id = '0;
		m_recent_exp = '0;
		m_recent_vld = 1'b0;
		for (int i = 0; i < OLDER; i++) begin
			m_old_id[i] = '0;
			m_old_exp[i] = '0;
			m_old_vld[i] = 1'b0;
		end
		m_retx = 1'b0;
	endtask

	// Exchange lifetime in ms, kept wide so nothing wraps before saturation
	function automatic logic [63:0] life_span_ms();
		logic [63:0] span;
		span = 64'(cfg_ack) * ((64'd1 << cfg_retx) - 64'd1);
		span = (span * 64'(cfg_factor)) >> 8;
		return span + 64'd2 * 64'(cfg_lat) + 64'(cfg_ack);
	endfunction

	// Apply one request to the model cache and return the result it should give
	function automatic mdc_res_t dedup_outcome(input mdc_req_t r);
		logic [TIME_W-1:0] now;
		logic [63:0] sum;
		logic [TIME_W-1:0] expiry;
		logic [TIME_W-1:0] best;
		int victim;
		bit have;
		mdc_res_t res;
		now = r.time_now_ms;
		// drop entries whose expiry lies strictly in the past
		if (m_recent_vld && m_recent_exp < now)
			m_recent_vld = 1'b0;
		for (int i = 0; i < OLDER; i++)
			if (m_old_vld[i] && m_old_exp[i] < now)
				m_old_vld[i] = 1'b0;
		if (r.opcode == OP_ADD) begin
			sum = 64'(now) + life_span_ms();
			expiry = (sum > 64'(TIME_MAX)) ? TIME_MAX : sum[TIME_W-1:0];
			if (m_recent_vld) begin
				// lowest free older slot, else smallest expiry with ties to the top index
				victim = 0;
				have = 0;
				best = '0;
				for (int i = 0; i < OLDER; i++) begin
					if (!m_old_vld[i]) begin
						victim = i;
						break;
					end
					if (!have || m_old_exp[i] <= best) begin
						have = 1;
						best = m_old_exp[i];
						victim = i;
					end
				end
				m_old_id[victim] = m_recent_id;
				m_old_exp[victim] = m_recent_exp;
				m_old_vld[victim] = 1'b1;
			end
			m_recent_id = r.msg_id;
			m_recent_exp = expiry;
			m_recent_vld = 1'b1;
			res.status = STATUS_STORED;
		end else begin
			res.status = STATUS_MISS;
			if (m_recent_vld && m_recent_id == r.msg_id) begin
				m_retx = 1'b1;
				res.status = STATUS_HIT_RECENT;
			end else begin
				for (int i = 0; i < OLDER; i++)
					if (m_old_vld[i] && m_old_id[i] == r.msg_id)
						res.status = STATUS_HIT_OLDER;
			end
		end
		res.retransmission = m_retx;
		return res;
	endfunction

	// Random idle bursts, with calm stretches and none at all when quiet
	function automatic int idle_gap();
		if (quiet)
			return 0;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 29) == 0) begin
			calm_left = $urandom_range(15, 40);
			return 0;
		end
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(1, 18);
		return 0;
	endfunction

	// Present a request and hold it until it is taken; start stays high afterwards,
	// so a back-to-back request never lowers and raises it in one step
	task automatic send_request(input mdc_req_t r, input logic typed, input mdc_res_t typed_res);
		mdc_res_t predicted;
		start <= 1'b1;
		request <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predicted = dedup_outcome(r);
		pending_outcomes.push_back(typed ? typed_res : predicted);
	endtask

	// Drop start and wait until every outstanding result is back and the unit is idle
	task automatic drain_outstanding();
		start <= 1'b0;
		@(posedge clk);
		while (pending_outcomes.size() != 0 || busy)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Write all four registers back to back; unused upper data bits get noise
	task automatic program_registers(input logic [ACK_W-1:0] a, input logic [RETX_W-1:0] rt,
			input logic [FACTOR_W-1:0] f, input logic [LAT_W-1:0] l);
		wr_en <= 1'b1;
		wr_index <= REG_ACK_TMO;
		wr_data <= {4'($urandom), a};
		@(posedge clk);
		cfg_ack = a;
		wr_index <= REG_MAX_RETX;
		wr_data <= {16'($urandom), rt};
		@(posedge clk);
		cfg_retx = rt;
		wr_index <= REG_RANDOM_FACTOR;
		wr_data <= {10'($urandom), f};
		@(posedge clk);
		cfg_factor = f;
		wr_index <= REG_MAX_LATENCY;
		wr_data <= l;
		@(posedge clk);
		cfg_lat = l;
		wr_en <= 1'b0;
	endtask

	// Compare every strobed result with the oldest expectation
	always @(posedge clk) begin : result_check
		mdc_res_t want;
		if (done) begin
			if (pending_outcomes.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual status %0d retx %0b",
					$time, result.status, result.retransmission);
				errors++;
			end else begin
				want = pending_outcomes.pop_front();
				if (result.status !== want.status) begin
					$display("%0t: status mismatch, expected %0d, actual %0d",
						$time, want.status, result.status);
					errors++;
				end
				if (result.retransmission !== want.retransmission) begin
					$display("%0t: retransmission mismatch, expected %0b, actual %0b",
						$time, want.retransmission, result.retransmission);
					errors++;
				end
			end
		end
	end

	initial begin : stimulus
		mdc_req_t r;
		mdc_res_t typed_res;
		logic [ID_W-1:0] id_pool [0:11];
		logic [ID_W-1:0] added_ids[$];
		logic [TIME_W-1:0] clock_ms;
		logic [63:0] life;
		logic [63:0] next_ms;
		int gap;
		int pick;
		int step_max;

		// Default settings: lifetime 247000 ms.
		// Rows: empty cache after reset, expiry equal to now, expiry just passed,
		// store into an empty recent slot, fill the older slots, evict the smallest
		// expiry, a tie on expiry, and saturation at the top of the time range.
		dir_rows = '{
			'{OP_CHECK, 16'h0000, 40'd0,      1'b1, STATUS_MISS,       1'b0},
			'{OP_CHECK, 16'hFFFF, 40'd0,      1'b1, STATUS_MISS,       1'b0},
			'{OP_ADD,   16'h1234, 40'd100,    1'b1, STATUS_STORED,     1'b0},
			'{OP_CHECK, 16'h1234, 40'd100,    1'b1, STATUS_HIT_RECENT, 1'b1},
			'{OP_CHECK, 16'h1234, 40'd247100, 1'b1, STATUS_HIT_RECENT, 1'b1},
			'{OP_CHECK, 16'h1234, 40'd247101, 1'b1, STATUS_MISS,       1'b1},
			'{OP_ADD,   16'hFFFF, 40'd300000, 1'b1, STATUS_STORED,     1'b1},
			'{OP_ADD,   16'h0000, 40'd300001, 1'b1, STATUS_STORED,     1'b1},
			'{OP_ADD,   16'h0001, 40'd300002, 1'b1, STATUS_STORED,     1'b1},
			'{OP_ADD,   16'h0002, 40'd300003, 1'b1, STATUS_STORED,     1'b1},
			'{OP_ADD,   16'h0003, 40'd300004, 1'b1, STATUS_STORED,     1'b1},
			'{OP_CHECK, 16'hFFFF, 40'd300005, 1'b0, STATUS_MISS,       1'b0},
			'{OP_CHECK, 16'h0000, 40'd300005, 1'b0, STATUS_MISS,       1'b0},
			'{OP_CHECK, 16'h0003, 40'd300005, 1'b0, STATUS_MISS,       1'b0},
			'{OP_ADD,   16'h0020, 40'd600000, 1'b1, STATUS_STORED,     1'b1},
			'{OP_ADD,   16'h0021, 40'd600000, 1'b1, STATUS_STORED,     1'b1},
			'{OP_ADD,   16'h0022, 40'd600000, 1'b1, STATUS_STORED,     1'b1},
			'{OP_ADD,   16'h0023, 40'd600000, 1'b1, STATUS_STORED,     1'b1},
			'{OP_ADD,   16'h0024, 40'd600000, 1'b1, STATUS_STORED,     1'b1},
			'{OP_CHECK, 16'h0022, 40'd600000, 1'b0, STATUS_MISS,       1'b0},
			'{OP_CHECK, 16'h0020, 40'd600000, 1'b0, STATUS_MISS,       1'b0},
			'{OP_ADD,   16'hABCD, TIME_MAX,   1'b1, STATUS_STORED,     1'b1},
			'{OP_CHECK, 16'hABCD, TIME_MAX,   1'b1, STATUS_HIT_RECENT, 1'b1},
			'{OP_CHECK, 16'h0024, TIME_MAX,   1'b0, STATUS_MISS,       1'b0}
		};

		cache_reset();
		// hold reset, then release it on a rising edge
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table with the reset settings
		for (int k = 0; k < DIR_N; k++) begin
			r.opcode = dir_rows[k].op;
			r.msg_id = dir_rows[k].id;
			r.time_now_ms = dir_rows[k].t_ms;
			typed_res.status = dir_rows[k].st;
			typed_res.retransmission = dir_rows[k].rt;
			gap = idle_gap();
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			send_request(r, dir_rows[k].typed, typed_res);
		end

		// Random streams, one register setting per phase
		for (int ph = 0; ph < PHASES; ph++) begin
			drain_outstanding();
			case (ph)
				0: program_registers(16'd2000, 4'd4, 10'd384, 20'd100000);
				1: program_registers(16'd1, 4'd0, 10'd256, 20'd0);
				2: program_registers(16'd65535, 4'd15, 10'd1023, 20'd1000000);
				3: program_registers(16'd0, 4'd0, 10'd0, 20'd0);
				4: program_registers(16'd65535, 4'd15, 10'd1023, 20'hFFFFF);
				7: program_registers(16'd300, 4'd2, 10'd700, 20'd50);
				default: program_registers(16'($urandom_range(1, 65535)),
					4'($urandom_range(0, 15)), 10'($urandom_range(256, 1023)),
					20'($urandom_range(0, 1000000)));
			endcase
			// no idling in the closing phase
			quiet = (ph == PHASES - 1);
			life = life_span_ms();
			step_max = (life / 3 > 64'd2000000000) ? 2000000000 : int'(life / 3) + 1;
			clock_ms = TIME_W'({$urandom, $urandom}) >> $urandom_range(8, 39);
			for (int i = 0; i < 12; i++)
				id_pool[i] = ID_W'($urandom);
			added_ids.delete();

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// advance the notional clock, mostly well inside one lifetime
				pick = $urandom_range(0, 99);
				if (pick < 4)
					next_ms = 64'(TIME_W'({$urandom, $urandom}));
				else if (pick < 8)
					next_ms = 64'(clock_ms) + life + 64'($urandom_range(1, 1000));
				else if (pick < 10)
					next_ms = 64'(TIME_MAX) - 64'($urandom_range(0, step_max)) * 64'd4;
				else
					next_ms = 64'(clock_ms) + 64'($urandom_range(0, step_max));
				clock_ms = (next_ms > 64'(TIME_MAX)) ? TIME_MAX : next_ms[TIME_W-1:0];
				r.time_now_ms = clock_ms;

				pick = $urandom_range(0, 99);
				if ($urandom_range(0, 99) < 45) begin
					r.opcode = OP_ADD;
					r.msg_id = (pick < 75) ? id_pool[$urandom_range(0, 11)] : ID_W'($urandom);
					added_ids.push_back(r.msg_id);
					if (added_ids.size() > 8)
						void'(added_ids.pop_front());
				end else begin
					r.opcode = OP_CHECK;
					if (pick < 45 && added_ids.size() > 0)
						r.msg_id = added_ids[$urandom_range(0, added_ids.size() - 1)];
					else if (pick < 75)
						r.msg_id = id_pool[$urandom_range(0, 11)];
					else
						r.msg_id = ID_W'($urandom);
				end

				gap = idle_gap();
				if (gap > 0) begin
					start <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				send_request(r, 1'b0, typed_res);
			end
		end

		// Let the last results come home, then give the verdict
		start <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Stop a hung run well beyond the slowest correct one
	initial begin : watchdog
		#400000;
		$display("simulation failed");
		$finish;
	end

endmodule
